// ===== design/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
package utf8d_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned GROUP_SIZE  = 4;

    localparam logic [7:0]  CONT_MASK  = 8'hC0;
    localparam logic [7:0]  CONT_TAG   = 8'h80;
    localparam logic [7:0]  LEAD2_MASK = 8'hE0;
    localparam logic [7:0]  LEAD2_TAG  = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK = 8'hF0;
    localparam logic [7:0]  LEAD3_TAG  = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK = 8'hF8;
    localparam logic [7:0]  LEAD4_TAG  = 8'hF0;

    localparam logic [20:0] MIN_CP2    = 21'h00080;
    localparam logic [20:0] MIN_CP3    = 21'h00800;
    localparam logic [20:0] MIN_CP4    = 21'h10000;
    localparam logic [20:0] SURR_LO    = 21'h0D800;
    localparam logic [20:0] SURR_HI    = 21'h0DFFF;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;

    localparam logic [2:0]  LEN_NONE   = 3'd0;
    localparam logic [2:0]  LEN_1      = 3'd1;
    localparam logic [2:0]  LEN_2      = 3'd2;
    localparam logic [2:0]  LEN_3      = 3'd3;
    localparam logic [2:0]  LEN_4      = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } byte_beat_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  bytes_used;
        logic        last_of_run;
    } cp_beat_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  bytes_used;
    } cp_item_t;

    // All results caused by one input byte; count is 1..4 when pushed.
    typedef struct packed {
        cp_item_t [GROUP_SIZE-1:0] items;
        logic [2:0]                count;
    } cp_group_t;

    typedef struct packed {
        logic      push;
        cp_group_t group;
    } group_push_t;

endpackage

// ===== design/utf8d_front.sv =====
// Front end: accepts text bytes, tracks the open sequence, builds result groups.
// Depends on utf8d_pkg.
module utf8d_front
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  byte_beat_t  byte_data,
    input  logic        queue_full,
    output group_push_t grp
);

    typedef struct packed {
        logic        emit;
        logic        open;
        logic [2:0]  need;
        logic [20:0] payload;
    } start_t;

    function automatic start_t decode_start(input logic [7:0] b, input logic eot);
        start_t s;
        s.emit    = 1'b0;
        s.open    = 1'b0;
        s.need    = LEN_NONE;
        s.payload = '0;
        if (b[7] == 1'b0) begin
            s.emit = 1'b1;
        end
        else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            s.need    = LEN_2;
            s.payload = {16'd0, b[4:0]};
        end
        else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            s.need    = LEN_3;
            s.payload = {17'd0, b[3:0]};
        end
        else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            s.need    = LEN_4;
            s.payload = {18'd0, b[2:0]};
        end
        else begin
            s.emit = 1'b1;
        end
        if (s.need != LEN_NONE) begin
            if (eot) begin
                s.emit = 1'b1;
            end
            else begin
                s.open = 1'b1;
            end
        end
        return s;
    endfunction

    logic [7:0]  lead_reg, lead_next;
    logic [2:0]  exp_reg, exp_next;
    logic [1:0]  col_reg, col_next;
    logic [20:0] part_reg, part_next;
    // Only two continuations are ever held: the third one closes the sequence.
    logic [7:0]  held_reg [2];
    logic [7:0]  held_next [2];

    logic        fire;
    logic [7:0]  b;
    logic        eot;
    logic        cont;
    logic        at_last;
    logic [20:0] v;
    logic [20:0] minv;
    logic        bad;
    start_t      st;
    cp_group_t   flush_grp;

    assign byte_stall = queue_full;
    assign fire       = byte_valid && !queue_full;
    assign b          = byte_data.text_byte;
    assign eot        = byte_data.end_of_text;
    assign cont       = (b & CONT_MASK) == CONT_TAG;
    assign at_last    = ({1'b0, col_reg} + 3'd2) >= exp_reg;
    assign v          = {part_reg[14:0], b[5:0]};
    assign st         = decode_start(b, eot);

    always_comb
    begin
        case (exp_reg)
            LEN_2:   minv = MIN_CP2;
            LEN_3:   minv = MIN_CP3;
            default: minv = MIN_CP4;
        endcase
    end

    assign bad = (v < minv) || ((v >= SURR_LO) && (v <= SURR_HI)) || (v > CP_MAX);

    // Lead, held continuations, then the current byte, each as a one-byte value.
    always_comb
    begin
        flush_grp.items[0] = '{code_point: {13'd0, lead_reg}, bytes_used: LEN_1};
        flush_grp.items[1] = '{code_point: {13'd0, (col_reg != 2'd0) ? held_reg[0] : b},
                               bytes_used: LEN_1};
        flush_grp.items[2] = '{code_point: {13'd0, (col_reg == 2'd2) ? held_reg[1] : b},
                               bytes_used: LEN_1};
        flush_grp.items[3] = '{code_point: {13'd0, b}, bytes_used: LEN_1};
        flush_grp.count    = {1'b0, col_reg} + 3'd1;
    end

    always_comb
    begin
        lead_next    = lead_reg;
        exp_next     = exp_reg;
        col_next     = col_reg;
        part_next    = part_reg;
        held_next[0] = held_reg[0];
        held_next[1] = held_reg[1];
        grp.group    = flush_grp;

        if (exp_reg == LEN_NONE) begin
            grp.group.items[0] = '{code_point: {13'd0, b}, bytes_used: LEN_1};
            grp.group.count    = st.emit ? LEN_1 : LEN_NONE;
            if (st.open) begin
                lead_next = b;
                exp_next  = st.need;
                col_next  = 2'd0;
                part_next = st.payload;
            end
        end
        else if (!cont) begin
            // broken sequence: replay, then this byte starts over
            grp.group.count = flush_grp.count + {2'b00, st.emit};
            lead_next = st.open ? b : 8'd0;
            exp_next  = st.open ? st.need : LEN_NONE;
            col_next  = 2'd0;
            part_next = st.open ? st.payload : 21'd0;
        end
        else if (at_last) begin
            if (bad) begin
                grp.group.count = flush_grp.count + 3'd1;
            end
            else begin
                grp.group.items[0] = '{code_point: v, bytes_used: exp_reg};
                grp.group.count    = LEN_1;
            end
            lead_next = 8'd0;
            exp_next  = LEN_NONE;
            col_next  = 2'd0;
            part_next = 21'd0;
        end
        else if (eot) begin
            grp.group.count = flush_grp.count + 3'd1;
            lead_next = 8'd0;
            exp_next  = LEN_NONE;
            col_next  = 2'd0;
            part_next = 21'd0;
        end
        else begin
            grp.group.count      = LEN_NONE;
            held_next[col_reg[0]] = b;
            part_next            = v;
            col_next             = col_reg + 2'd1;
        end

        grp.push = fire && (grp.group.count != LEN_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lead_reg <= '0;
            exp_reg  <= LEN_NONE;
            col_reg  <= '0;
            part_reg <= '0;
        end
        else if (fire) begin
            lead_reg <= lead_next;
            exp_reg  <= exp_next;
            col_reg  <= col_next;
            part_reg <= part_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            held_reg[0] <= held_next[0];
            held_reg[1] <= held_next[1];
        end
    end

endmodule

// ===== design/utf8d_queue.sv =====
// Short queue of result groups between the front end and the back end.
// Depends on utf8d_pkg.
module utf8d_queue
    import utf8d_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  group_push_t grp,
    output logic        full,
    output logic        empty,
    output cp_group_t   head,
    input  logic        pop
);

    localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned CntW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

    cp_group_t       slot_reg [QueueDepth];
    logic [PtrW-1:0] wr_reg, wr_next;
    logic [PtrW-1:0] rd_reg, rd_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full    = cnt_reg == CntFull;
    assign empty   = cnt_reg == '0;
    assign head    = slot_reg[rd_reg];
    assign do_push = grp.push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PtrLast) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == PtrLast) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_reg] <= grp.group;
        end
    end

endmodule

// ===== design/utf8d_back.sv =====
// Back end: walks the head group and hands out one code point per beat.
// Depends on utf8d_pkg.
module utf8d_back
    import utf8d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      empty,
    input  cp_group_t head,
    output logic      pop,
    output logic      cp_valid,
    input  logic      cp_stall,
    output cp_beat_t  cp_data
);

    logic [1:0] idx_reg, idx_next;
    logic       last;
    logic       take;

    assign last     = ({1'b0, idx_reg} + 3'd1) == head.count;
    assign cp_valid = !empty;
    assign take     = cp_valid && !cp_stall;
    assign pop      = take && last;

    always_comb
    begin
        cp_data.code_point  = head.items[idx_reg].code_point;
        cp_data.bytes_used  = head.items[idx_reg].bytes_used;
        cp_data.last_of_run = last;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (take) begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
        end
        else begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== design/utf8_stream_decoder_core.sv =====
// Top level of the UTF-8 stream decoder: front end, group queue, back end.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back.
//
//   channel | dir | handshake            | beat
//   --------+-----+----------------------+---------------------------------------
//   byte    | in  | byte_valid/byte_stall| byte_data: text_byte, end_of_text
//   cp      | out | cp_valid/cp_stall    | cp_data: code_point, bytes_used, last
//
// One text byte is taken per cycle while the group queue has room; each
// result goes out as its own beat on the output, so a byte that causes k
// results (1..4) occupies the back end for k beats. Valid text runs at one
// byte per cycle while cp_stall is low. Results pass through the group
// queue. Reset closes any open sequence and empties the queue. Output stalls
// fill the queue and then raise byte_stall.
module utf8_stream_decoder_core
    import utf8d_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_beat_t byte_data,
    output logic       cp_valid,
    input  logic       cp_stall,
    output cp_beat_t   cp_data
);

    group_push_t grp;
    cp_group_t   head;
    logic        full;
    logic        empty;
    logic        pop;

    utf8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .queue_full (full),
        .grp        (grp)
    );

    utf8d_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .grp   (grp),
        .full  (full),
        .empty (empty),
        .head  (head),
        .pop   (pop)
    );

    utf8d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .cp_valid (cp_valid),
        .cp_stall (cp_stall),
        .cp_data  (cp_data)
    );

endmodule
